// ===== src/atm_pkg.sv =====
// Shared types, codes and sizes for the alarm table match block.
`default_nettype none

package atm_pkg;

    localparam int MAX_ALARMS = 16;
    localparam int ADDR_W     = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

    localparam int TIME_W     = 12;
    localparam int TONE_W     = 8;
    localparam int INDEX_W    = 4;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int COUNT_W    = 5;

    localparam logic [TIME_W-1:0] TIME_LIMIT = TIME_W'(2400);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_CHECK = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_TIME  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_FIN
    } t_state;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [TIME_W-1:0] wake_time;
    } t_entry;

    // One result item.
    typedef struct packed {
        t_status           status;
        logic              ring;
        logic [TONE_W-1:0] tone;
        logic [TIME_W-1:0] ring_time;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_result;

    // Control group for the shared match unit.
    typedef struct packed {
        logic                load;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_match_ctl;

endpackage

`default_nettype wire

// ===== src/alarm_table_match.sv =====
// Top level of the alarm table: sequencer, entry RAM and shared match unit.
// Flow: add, unused opcodes and rejected requests go through S_START and S_FIN to
// the output register; delete and check walk M entries through S_READ and S_EVAL
// before S_FIN, and any output stall holds their results back.
// Throughput: one request at a time; s_tready is high only while idle, so a
// request is finished before the next is taken (M up to 16).
// Reset: i_rst_n (synchronous, active low) empties the table and the output
// register; the entry RAM itself is not cleared and needs no clearing pass.
`default_nettype none

module alarm_table_match (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata, low bit up: wake_time[11:0], tone[19:12], index[23:20],
    // cur_hour[28:24], cur_minute[34:29], zero fill[39:35]
    input  wire logic [39:0] s_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata, low bit up: status[1:0], ring_tone[9:2], ring_time[21:10],
    // alarm_count[26:22], zero fill[31:27]
    output logic      [31:0] m_tdata,
    // tuser: ring[0]
    output logic      [0:0]  m_tuser,
    output logic             m_tlast
);
    import atm_pkg::*;

    // ------------------------------------------------------------------
    // Sequencer state and latched request fields.
    // ------------------------------------------------------------------
    t_state              r_state,  n_state;
    logic [1:0]          r_op,     n_op;
    logic [TIME_W-1:0]   r_time,   n_time;
    logic [TONE_W-1:0]   r_tone,   n_tone;
    logic [INDEX_W-1:0]  r_index,  n_index;
    logic [HOUR_W-1:0]   r_hour,   n_hour;
    logic [MINUTE_W-1:0] r_minute, n_minute;

    // Table bookkeeping: live entry count, scan limit, read and write slots.
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [CNT_W-1:0]    r_limit,  n_limit;
    logic [CNT_W-1:0]    r_rd,     n_rd;
    logic [CNT_W-1:0]    r_wr,     n_wr;
    logic                r_check,  n_check;
    t_status             r_status, n_status;

    // A match waits here until the scan shows whether it is the final one.
    logic                r_pend_valid, n_pend_valid;
    t_result             r_pend,       n_pend;

    // Output register parts the result side from the sequencer.
    logic                r_out_valid,  n_out_valid;
    t_result             r_out,        n_out;

    // RAM and match unit hookup.
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_entry              mem_wdata;
    t_entry              mem_rdata;
    t_match_ctl          match_ctl;
    logic                hit;
    logic                out_free;

    atm_ram #(
        .WIDTH (($bits(t_entry))),
        .DEPTH (MAX_ALARMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    atm_match u_match (
        .i_clk  (i_clk),
        .i_ctl  (match_ctl),
        .i_time (mem_rdata.wake_time),
        .o_hit  (hit)
    );

    // Hold off requests while reset is asserted.
    assign s_tready = (r_state == S_IDLE) && i_rst_n;
    assign out_free = !r_out_valid || m_tready;

    // ------------------------------------------------------------------
    // State register and control.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and scan registers need no reset.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_time   <= n_time;
        r_tone   <= n_tone;
        r_index  <= n_index;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_limit  <= n_limit;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_check  <= n_check;
        r_status <= n_status;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    // ------------------------------------------------------------------
    // Next state and datapath control.
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_time       = r_time;
        n_tone       = r_tone;
        n_index      = r_index;
        n_hour       = r_hour;
        n_minute     = r_minute;
        n_count      = r_count;
        n_limit      = r_limit;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_check      = r_check;
        n_status     = r_status;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !m_tready;
        n_out        = r_out;

        mem_we           = 1'b0;
        mem_waddr        = r_wr[ADDR_W-1:0];
        mem_wdata        = mem_rdata;
        match_ctl.load   = 1'b0;
        match_ctl.hour   = r_hour;
        match_ctl.minute = r_minute;

        unique case (r_state)
            S_IDLE: begin
                // Take a request and unpack its fields.
                if (s_tvalid) begin
                    n_op     = s_tuser;
                    n_time   = s_tdata[11:0];
                    n_tone   = s_tdata[19:12];
                    n_index  = s_tdata[23:20];
                    n_hour   = s_tdata[28:24];
                    n_minute = s_tdata[34:29];
                    n_state  = S_START;
                end
            end

            S_START: begin
                n_pend_valid = 1'b0;
                n_status     = ST_OK;
                n_state      = S_FIN;
                unique case (r_op)
                    OP_ADD: begin
                        // Time range is tested before the table fill.
                        if (r_time >= TIME_LIMIT) begin
                            n_status = ST_BAD_TIME;
                        end else if (32'(r_count) >= MAX_ALARMS) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[ADDR_W-1:0];
                            mem_wdata = '{tone: r_tone, wake_time: r_time};
                            n_count   = r_count + 1'b1;
                        end
                    end
                    OP_DEL: begin
                        // Close the gap: copy every later entry down one slot.
                        if (32'(r_index) < 32'(r_count)) begin
                            n_rd    = CNT_W'(r_index) + 1'b1;
                            n_wr    = CNT_W'(r_index);
                            n_limit = r_count;
                            n_count = r_count - 1'b1;
                            n_check = 1'b0;
                            n_state = S_READ;
                        end else begin
                            n_status = ST_BAD_INDEX;
                        end
                    end
                    OP_CHECK: begin
                        // Load the target time and scan the whole table.
                        match_ctl.load = 1'b1;
                        n_rd    = '0;
                        n_wr    = '0;
                        n_limit = r_count;
                        n_check = 1'b1;
                        n_state = S_READ;
                    end
                    default: begin
                        // Unused opcode: plain ok result.
                    end
                endcase
            end

            S_READ: begin
                // RAM read of slot r_rd is in flight; stop at the scan limit.
                if (r_rd >= r_limit) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                if (r_check && hit) begin
                    // Drop the entry; push the older pending match first.
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            n_out       = r_pend;
                            n_out.last  = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        n_pend_valid    = 1'b1;
                        n_pend.status   = ST_OK;
                        n_pend.ring     = 1'b1;
                        n_pend.tone     = mem_rdata.tone;
                        n_pend.ring_time = mem_rdata.wake_time;
                        n_pend.count    = r_count - 1'b1;
                        n_pend.last     = 1'b0;
                        n_count         = r_count - 1'b1;
                        n_rd            = r_rd + 1'b1;
                        n_state         = S_READ;
                    end
                end else begin
                    // Keep the entry: move it down to the write slot.
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[ADDR_W-1:0];
                    mem_wdata = mem_rdata;
                    n_wr      = r_wr + 1'b1;
                    n_rd      = r_rd + 1'b1;
                    n_state   = S_READ;
                end
            end

            S_FIN: begin
                // Hand over the final result of this request.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out.status    = r_status;
                        n_out.ring      = 1'b0;
                        n_out.tone      = '0;
                        n_out.ring_time = '0;
                        n_out.count     = r_count;
                        n_out.last      = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result port packing.
    // ------------------------------------------------------------------
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b0, COUNT_W'(r_out.count), r_out.ring_time, r_out.tone,
                       r_out.status};
    assign m_tuser  = r_out.ring;
    assign m_tlast  = r_out.last;

endmodule

`default_nettype wire

// ===== src/atm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module atm_ram #(
    parameter int WIDTH  = 20,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/atm_match.sv =====
// Shared time compare unit: holds hour*100+minute and tests one entry a cycle.
`default_nettype none

module atm_match (
    input  wire logic                       i_clk,
    input  wire atm_pkg::t_match_ctl        i_ctl,
    input  wire logic [atm_pkg::TIME_W-1:0] i_time,
    output logic                            o_hit
);
    import atm_pkg::*;

    logic [TIME_W-1:0] r_target;
    logic [TIME_W-1:0] n_target;

    // hour*100 = hour*64 + hour*32 + hour*4; minute stays below 100, so one
    // equality test covers both the quotient and the remainder.
    always_comb begin
        n_target = (TIME_W'(i_ctl.hour) << 6) + (TIME_W'(i_ctl.hour) << 5)
                 + (TIME_W'(i_ctl.hour) << 2) + TIME_W'(i_ctl.minute);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_target <= n_target;
        end
    end

    assign o_hit = (r_target == i_time);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for alarm_table_match: directed and random requests.

module tb_top;
    import atm_pkg::*;

    // Opcode the block must ignore, still answered with one plain result.
    localparam logic [1:0] OP_SPARE     = 2'd3;
    localparam int         RANDOM_REQS  = 320;
    localparam int         LONG_HOLD    = 80;
    // A full check walks all 16 entries, each through a read and an evaluate state.
    localparam int         DRAIN_CYCLES = 2 * MAX_ALARMS + 8;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         HOUR_SCALE   = 100;
    localparam int         POOL_SIZE    = 6;

    // Table model: holds the alarm entries and the results still owed by the block.
    class alarm_ledger;
        logic [TIME_W-1:0] times [MAX_ALARMS];
        logic [TONE_W-1:0] tones [MAX_ALARMS];
        int unsigned       used;
        t_result           due_results [$];
        int unsigned       mismatches;

        function new();
            used       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function string describe(t_result r);
            return $sformatf("status=%0d ring=%0d tone=%0d time=%0d count=%0d last=%0d",
                             r.status, r.ring, r.tone, r.ring_time, r.count, r.last);
        endfunction

        // Close the gap left at pos, keeping table order.
        function void drop_entry(int unsigned pos);
            for (int unsigned i = pos; i + 1 < used; i++) begin
                times[i] = times[i + 1];
                tones[i] = tones[i + 1];
            end
            used--;
        endfunction

        function void push_result(t_status status, logic ring, logic [TONE_W-1:0] tone,
                                  logic [TIME_W-1:0] atime, logic last);
            t_result r;
            r.status    = status;
            r.ring      = ring;
            r.tone      = tone;
            r.ring_time = atime;
            r.count     = CNT_W'(used);
            r.last      = last;
            due_results.push_back(r);
        endfunction

        // Update the table for one accepted request and queue the results it owes.
        function void apply_request(logic [1:0] op, logic [TIME_W-1:0] atime,
                                    logic [TONE_W-1:0] tone, logic [INDEX_W-1:0] index,
                                    logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute);
            int unsigned       i;
            int unsigned       rang;
            logic [TIME_W-1:0] hit_time;
            logic [TONE_W-1:0] hit_tone;
            t_result           final_ring;
            case (op)
                OP_ADD: begin
                    if (atime >= TIME_LIMIT) begin
                        push_result(ST_BAD_TIME, 1'b0, '0, '0, 1'b1);
                    end else if (used >= MAX_ALARMS) begin
                        push_result(ST_FULL, 1'b0, '0, '0, 1'b1);
                    end else begin
                        times[used] = atime;
                        tones[used] = tone;
                        used++;
                        push_result(ST_OK, 1'b0, '0, '0, 1'b1);
                    end
                end
                OP_DEL: begin
                    if (index < used) begin
                        drop_entry(index);
                        push_result(ST_OK, 1'b0, '0, '0, 1'b1);
                    end else begin
                        push_result(ST_BAD_INDEX, 1'b0, '0, '0, 1'b1);
                    end
                end
                OP_CHECK: begin
                    i    = 0;
                    rang = 0;
                    // Rescan the slot a removal refills, so no entry is skipped.
                    while (i < used) begin
                        if (times[i] / HOUR_SCALE == hour && times[i] % HOUR_SCALE == minute) begin
                            hit_time = times[i];
                            hit_tone = tones[i];
                            drop_entry(i);
                            push_result(ST_OK, 1'b1, hit_tone, hit_time, 1'b0);
                            rang++;
                        end else begin
                            i++;
                        end
                    end
                    if (rang == 0) begin
                        push_result(ST_OK, 1'b0, '0, '0, 1'b1);
                    end else begin
                        final_ring      = due_results.pop_back();
                        final_ring.last = 1'b1;
                        due_results.push_back(final_ring);
                    end
                end
                default: begin
                    push_result(ST_OK, 1'b0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one accepted result with the oldest owed result, field by field.
        task match_result(t_result got);
            t_result want;
            string   diffs;
            if (due_results.size() == 0) begin
                flag_mismatch({"unexpected result ", describe(got)});
                return;
            end
            want  = due_results.pop_front();
            diffs = "";
            if (got.status !== want.status)       diffs = {diffs, " status"};
            if (got.ring !== want.ring)           diffs = {diffs, " ring"};
            if (got.tone !== want.tone)           diffs = {diffs, " tone"};
            if (got.ring_time !== want.ring_time) diffs = {diffs, " time"};
            if (got.count !== want.count)         diffs = {diffs, " count"};
            if (got.last !== want.last)           diffs = {diffs, " last"};
            if (diffs != "") begin
                flag_mismatch($sformatf("field(s)%s: got %s, want %s",
                                        diffs, describe(got), describe(want)));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // tdata, low bit up: wake_time, tone, index, cur_hour, cur_minute, zero fill
    logic [39:0] s_tdata;
    // tuser: opcode
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // tdata, low bit up: status, ring_tone, ring_time, alarm_count, zero fill
    logic [31:0] m_tdata;
    // tuser: ring
    logic [0:0]  m_tuser;
    logic        m_tlast;

    alarm_ledger book = new();

    // Shared between the sender and the receiver: calm turns off random idling,
    // hold_req asks the receiver for one long hold-off.
    bit          calm;
    bit          hold_req;
    int          time_pool [POOL_SIZE];
    int unsigned stall_cycles;

    alarm_table_match dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request and hold it until the block takes it; note it in the model
    // at the accepting edge, then idle for a short burst now and then.
    task automatic send_request(input logic [1:0] op, input logic [TIME_W-1:0] atime,
                                input logic [TONE_W-1:0] tone,
                                input logic [INDEX_W-1:0] index,
                                input logic [HOUR_W-1:0] hour,
                                input logic [MINUTE_W-1:0] minute);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, minute, hour, index, tone, atime};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        book.apply_request(op, atime, tone, index, hour, minute);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every owed result before going on.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (book.pending() != 0);
    endtask

    // Favor a small pool of times so adds collide and checks ring several entries.
    function automatic logic [TIME_W-1:0] pick_add_time();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return TIME_W'(time_pool[$urandom_range(0, POOL_SIZE - 1)]);
        if (roll < 9) return TIME_W'($urandom_range(0, 2399));
        return TIME_W'($urandom_range(2400, 4095));
    endfunction

    // Receiver: one decision per edge, so m_tready gets a single update per step.
    initial begin : receiver
        int unsigned stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status    = t_status'(m_tdata[1:0]);
            got.tone      = m_tdata[9:2];
            got.ring_time = m_tdata[21:10];
            got.count     = m_tdata[26:22];
            got.ring      = m_tuser[0];
            got.last      = m_tlast;
            book.match_result(got);
        end
    end

    // Watchdog: end the run if neither side moves a request or result for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [1:0]          r_op;
        logic [TIME_W-1:0]   r_time;
        logic [TONE_W-1:0]   r_tone;
        logic [INDEX_W-1:0]  r_index;
        logic [HOUR_W-1:0]   r_hour;
        logic [MINUTE_W-1:0] r_minute;
        logic [TIME_W-1:0]   picked;
        int unsigned         roll;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        i_rst_n      = 1'b0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        for (int p = 0; p < POOL_SIZE; p++) begin
            time_pool[p] = $urandom_range(0, 23) * HOUR_SCALE + $urandom_range(0, 59);
        end

        // Hold reset, then release it once.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: time extremes, bad times, misses and bad indexes.
        send_request(OP_ADD,   12'd0,    8'd0,   4'd0,  5'd0,  6'd0);
        send_request(OP_ADD,   12'd2399, 8'd255, 4'd0,  5'd0,  6'd0);
        send_request(OP_ADD,   12'd2400, 8'd1,   4'd0,  5'd0,  6'd0);
        send_request(OP_ADD,   12'd4095, 8'd255, 4'd0,  5'd0,  6'd0);
        send_request(OP_CHECK, 12'd0,    8'd0,   4'd0,  5'd23, 6'd59);
        // Hour and minute past their clock range simply match nothing.
        send_request(OP_CHECK, 12'd0,    8'd0,   4'd0,  5'd31, 6'd63);
        send_request(OP_DEL,   12'd0,    8'd0,   4'd15, 5'd0,  6'd0);
        send_request(OP_DEL,   12'd0,    8'd0,   4'd0,  5'd0,  6'd0);
        send_request(OP_DEL,   12'd0,    8'd0,   4'd0,  5'd0,  6'd0);
        send_request(OP_SPARE, 12'd4095, 8'd255, 4'd15, 5'd31, 6'd63);
        // Fill the table with one time, overflow it, then ring every entry at once.
        for (int k = 0; k < MAX_ALARMS; k++) begin
            send_request(OP_ADD, 12'd730, TONE_W'(k * 17), 4'd0, 5'd0, 6'd0);
        end
        send_request(OP_ADD,   12'd730,  8'd99,  4'd0,  5'd0,  6'd0);
        send_request(OP_CHECK, 12'd0,    8'd0,   4'd0,  5'd7,  6'd30);

        // Random: mostly adds and checks that hit stored times, some noise.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 300 && n < 330) || (n >= RANDOM_REQS - 60);
            if (n == 100 || n == 260) pause_until_drained();
            // Hold the receiver off while requests keep coming, to back up the input.
            if (n == 160) hold_req = 1'b1;

            r_time   = TIME_W'($urandom);
            r_tone   = TONE_W'($urandom);
            r_index  = INDEX_W'($urandom);
            r_hour   = HOUR_W'($urandom);
            r_minute = MINUTE_W'($urandom);
            roll     = $urandom_range(0, 39);

            if (roll == 39) begin
                // Fill to the top and push one more add into the full table.
                while (book.used < MAX_ALARMS) begin
                    send_request(OP_ADD, TIME_W'(time_pool[$urandom_range(0, POOL_SIZE - 1)]),
                                 TONE_W'($urandom), r_index, r_hour, r_minute);
                end
                send_request(OP_ADD, TIME_W'($urandom_range(0, 2399)), r_tone,
                             r_index, r_hour, r_minute);
            end else begin
                if (roll < 16) begin
                    r_op   = OP_ADD;
                    r_time = pick_add_time();
                end else if (roll < 24) begin
                    r_op = OP_DEL;
                    if (book.used > 0 && $urandom_range(0, 4) != 0) begin
                        r_index = INDEX_W'($urandom_range(0, book.used - 1));
                    end
                end else if (roll < 37) begin
                    r_op = OP_CHECK;
                    if (book.used > 0 && $urandom_range(0, 3) != 0) begin
                        picked   = book.times[$urandom_range(0, book.used - 1)];
                        r_hour   = HOUR_W'(picked / HOUR_SCALE);
                        r_minute = MINUTE_W'(picked % HOUR_SCALE);
                    end
                end else begin
                    r_op = OP_SPARE;
                end
                send_request(r_op, r_time, r_tone, r_index, r_hour, r_minute);
            end
        end

        // Drain: wait for every owed result, then a little longer for strays.
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
